@@ hdl/sart_pkg.sv @@
// Shared types and constants for the set-associative replacement table.
`default_nettype none
package sart_pkg;
	localparam logic [2:0] KIND_PROBE = 3'd0;
	localparam logic [2:0] KIND_STORE = 3'd1;
	localparam logic [2:0] KIND_NEWSEARCH = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_FILL = 3'd4;

	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_LOWER = 2'd1;

	localparam logic [1:0] OUT_DROPPED = 2'd0;
	localparam logic [1:0] OUT_WRITTEN = 2'd1;
	localparam logic [1:0] OUT_REFRESHED = 2'd2;

	// one way as kept in memory
	typedef struct packed {
		logic [63:0] key;
		logic [7:0] depth;
		logic [15:0] score;
		logic [1:0] bound;
		logic [15:0] move;
		logic [15:0] eval;
		logic [7:0] gen;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0] kind;
		logic [63:0] key;
		logic [7:0] depth;
		logic signed [15:0] score;
		logic [1:0] bound;
		logic [15:0] move_in;
		logic signed [15:0] eval_in;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic [7:0] found_depth;
		logic signed [15:0] found_score;
		logic [1:0] found_bound;
		logic [15:0] found_move;
		logic signed [15:0] found_eval;
		logic [1:0] store_outcome;
		logic [9:0] fill_permille;
	} rsp_t;

	// bound bonus, as a signed 12-bit value
	function automatic logic signed [11:0] bonus_of(input logic [1:0] b);
		unique case (b)
			BOUND_EXACT: bonus_of = 12'sd256;
			BOUND_LOWER: bonus_of = 12'sd128;
			default: bonus_of = 12'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

@@ hdl/sart_if.sv @@
// Valid/ready channel interface carrying one item.
`default_nettype none
interface sart_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/set_assoc_replacement_table.sv @@
// Set-associative replacement table: sequencer over one way memory and one scoring unit.
//
// One input channel (cmd) carries commands: probe, store, new search, clear,
// fill query. One output channel (rsp) returns exactly one item per command.
// The ways sit in one RAM of BUCKETS*WAYS words, one way per word, so all work
// goes through its single port, one way per cycle, and a single score/compare
// unit evaluates one way a cycle.
// Probe scans the bucket; store scans it, then writes back; new search and
// unused kinds answer with no memory access; clear writes every way (one way
// a cycle); fill query scans S*WAYS ways, then does one reciprocal multiply,
// with S = min(FILL_SAMPLE, BUCKETS). The next command is taken only after
// the response has been accepted.
// After reset a clearing pass writes every way to zero; cmd.ready stays low
// meanwhile and the generation is one.
// One command is in flight at a time; cmd.ready is high only when idle and the
// output register is empty. If the receiver stalls, the result holds in the
// output register and no new command is taken.
`default_nettype none
module set_assoc_replacement_table #(
	parameter int BUCKETS = 4096,
	parameter int WAYS = 4,
	parameter int FILL_SAMPLE = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	sart_if.sink cmd,
	sart_if.source rsp
);
	localparam int TOTAL = BUCKETS * WAYS;
	localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SAMPLE = (FILL_SAMPLE < BUCKETS) ? FILL_SAMPLE : BUCKETS;
	localparam int NSAMP = SAMPLE * WAYS;
	localparam int CW = $clog2(NSAMP + 1);
	localparam int NUMW = CW + 10;
	// reciprocal of the sample size, exact for every numerator below 2**NUMW
	localparam int RK = NUMW + $clog2(NSAMP);
	localparam int MW = NUMW + 2;
	localparam int PW = NUMW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << RK) + 64'(NSAMP) - 64'd1) / 64'(NSAMP));

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_SCAN = 4'd2;
	localparam logic [3:0] ST_WRITE = 4'd3;
	localparam logic [3:0] ST_FILL = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_CLEAR = 4'd6;

	logic [3:0] state_q;
	sart_pkg::cmd_t cmd_q;
	logic [7:0] gen_q;
	logic [AW-1:0] addr_q;
	logic [WW:0] rcnt_q;
	logic [WW-1:0] rway_q;
	logic [AW-1:0] base_q;
	// scan results
	logic eq_found_q, emp_found_q, worst_v_q;
	logic [WW-1:0] eq_way_q, emp_way_q, worst_way_q;
	logic signed [12:0] worst_sc_q;
	sart_pkg::entry_t eq_ent_q, worst_ent_q;
	// fill counter and scaled count
	logic [CW-1:0] used_q;
	logic [NUMW-1:0] num_q;
	logic ovalid_q;
	sart_pkg::rsp_t out_q;

	logic we;
	logic [AW-1:0] ram_addr;
	sart_pkg::entry_t wdata, rdata;

	sart_ram #(.WIDTH(sart_pkg::ENTRY_W), .DEPTH(TOTAL)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
	);

	// bucket base for the incoming key
	logic [AW-1:0] in_base;
	always_comb begin
		in_base = AW'(AW'(cmd.data.key % 64'(BUCKETS)) * AW'(WAYS));
	end

	// shared scoring unit: resident score of the way just read
	logic [7:0] age;
	logic signed [12:0] rd_sc;
	always_comb begin
		age = gen_q - rdata.gen;
		rd_sc = $signed({2'b00, rdata.depth, 3'b000}) + 13'(sart_pkg::bonus_of(rdata.bound))
			- $signed({3'b000, age, 2'b00});
	end

	// store decision
	logic [WW-1:0] sel_way;
	sart_pkg::entry_t sel_ent, new_ent;
	logic signed [12:0] in_sc, sel_sc;
	logic drop, refresh;
	always_comb begin
		sel_way = worst_way_q;
		sel_ent = worst_ent_q;
		sel_sc = worst_sc_q;
		if (eq_found_q) begin
			sel_way = eq_way_q;
			sel_ent = eq_ent_q;
		end else if (emp_found_q) begin
			sel_way = emp_way_q;
			sel_ent = '0;
		end
		in_sc = $signed({2'b00, cmd_q.depth, 3'b000}) + 13'(sart_pkg::bonus_of(cmd_q.bound));
		drop = !eq_found_q && !emp_found_q && (in_sc < sel_sc);
		refresh = eq_found_q && ({1'b0, cmd_q.depth} + 9'd2 < {1'b0, sel_ent.depth})
			&& sel_ent.bound == sart_pkg::BOUND_EXACT
			&& cmd_q.bound != sart_pkg::BOUND_EXACT;
		new_ent.key = cmd_q.key;
		new_ent.depth = cmd_q.depth;
		new_ent.score = cmd_q.score;
		new_ent.bound = cmd_q.bound;
		new_ent.move = (eq_found_q && cmd_q.move_in == 16'd0) ? sel_ent.move
			: cmd_q.move_in;
		new_ent.eval = cmd_q.eval_in;
		new_ent.gen = gen_q;
		if (refresh) begin
			new_ent = sel_ent;
			new_ent.gen = gen_q;
		end
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		wdata = new_ent;
		ram_addr = addr_q;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			we = 1'b1;
			wdata = '0;
		end else if (state_q == ST_WRITE) begin
			we = !drop;
			ram_addr = base_q + AW'(sel_way);
		end else if (state_q == ST_IDLE) begin
			// fill query starts its walk at way zero
			ram_addr = (cmd.data.kind == sart_pkg::KIND_FILL) ? '0 : in_base;
		end
	end

	assign cmd.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign rsp.valid = ovalid_q;
	assign rsp.data = out_q;

	// scaled count times the reciprocal gives the per mille figure
	logic [PW-1:0] prod;
	always_comb begin
		prod = PW'(num_q) * PW'(RECIP);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			gen_q <= 8'd1;
			addr_q <= '0;
			ovalid_q <= 1'b0;
			rcnt_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(TOTAL - 1)) begin
						if (state_q == ST_CLEAR) begin
							ovalid_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						cmd_q <= cmd.data;
						out_q <= '0;
						base_q <= in_base;
						rcnt_q <= '0;
						rway_q <= '0;
						eq_found_q <= 1'b0;
						emp_found_q <= 1'b0;
						worst_v_q <= 1'b0;
						used_q <= '0;
						unique case (cmd.data.kind)
							sart_pkg::KIND_PROBE, sart_pkg::KIND_STORE: begin
								addr_q <= in_base + AW'(1);
								state_q <= ST_SCAN;
							end
							sart_pkg::KIND_NEWSEARCH: begin
								gen_q <= (gen_q == 8'hFF) ? 8'd1 : gen_q + 8'd1;
								ovalid_q <= 1'b1;
							end
							sart_pkg::KIND_CLEAR: begin
								addr_q <= '0;
								state_q <= ST_CLEAR;
							end
							sart_pkg::KIND_FILL: begin
								addr_q <= AW'(1);
								state_q <= ST_FILL;
							end
							default: ovalid_q <= 1'b1;
						endcase
					end
				end
				ST_SCAN: begin
					// one way arrives each cycle
					addr_q <= addr_q + AW'(1);
					rway_q <= rway_q + WW'(1);
					rcnt_q <= rcnt_q + (WW+1)'(1);
					if (rdata.key == cmd_q.key && !eq_found_q) begin
						eq_found_q <= 1'b1;
						eq_way_q <= rway_q;
						eq_ent_q <= rdata;
					end
					if (rdata.key == 64'd0 && !emp_found_q) begin
						emp_found_q <= 1'b1;
						emp_way_q <= rway_q;
					end
					if (!worst_v_q || rd_sc < worst_sc_q) begin
						worst_v_q <= 1'b1;
						worst_sc_q <= rd_sc;
						worst_way_q <= rway_q;
						worst_ent_q <= rdata;
					end
					if (rcnt_q == (WW+1)'(WAYS - 1)) begin
						if (cmd_q.kind == sart_pkg::KIND_STORE) begin
							state_q <= ST_WRITE;
						end else begin
							if (rdata.key == cmd_q.key && !eq_found_q) begin
								out_q.hit <= 1'b1;
								out_q.found_depth <= rdata.depth;
								out_q.found_score <= rdata.score;
								out_q.found_bound <= rdata.bound;
								out_q.found_move <= rdata.move;
								out_q.found_eval <= rdata.eval;
							end else if (eq_found_q) begin
								out_q.hit <= 1'b1;
								out_q.found_depth <= eq_ent_q.depth;
								out_q.found_score <= eq_ent_q.score;
								out_q.found_bound <= eq_ent_q.bound;
								out_q.found_move <= eq_ent_q.move;
								out_q.found_eval <= eq_ent_q.eval;
							end
							ovalid_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WRITE: begin
					out_q.store_outcome <= drop ? sart_pkg::OUT_DROPPED
						: (refresh ? sart_pkg::OUT_REFRESHED : sart_pkg::OUT_WRITTEN);
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					// count current-generation ways, one a cycle
					addr_q <= addr_q + AW'(1);
					if (rdata.key != 64'd0 && rdata.gen == gen_q) begin
						used_q <= used_q + CW'(1);
					end
					if (addr_q == AW'(NSAMP)) begin
						num_q <= NUMW'((rdata.key != 64'd0 && rdata.gen == gen_q)
							? used_q + CW'(1) : used_q) * NUMW'(1000);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// take the quotient from the reciprocal product
					out_q.fill_permille <= prod[RK +: 10];
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/sart_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module sart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read one word, and write it when enabled (the read returns the old word)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire
